// File: rtl/ibsm_pkg.sv
// Shared types and constants for the IFS block symmetry map.
package ibsm_pkg;

  localparam int PIX_W = 8;
  localparam int SCALE_W = 16;
  localparam int OFFS_W = 10;
  localparam int SYM_W = 3;
  localparam int SIZE_W = 6;
  localparam int COORD_W = 12;
  localparam int SUM_W = COORD_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS = 12;
  localparam int PIX_MAX = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_SYMMETRY = 3'd2,
    REG_SIZE     = 3'd3,
    REG_ORIGIN_X = 3'd4,
    REG_ORIGIN_Y = 3'd5
  } reg_idx_e;

  typedef enum logic [SYM_W-1:0] {
    ORIENT_IDENT         = 3'd0,
    ORIENT_ROT90         = 3'd1,
    ORIENT_ROT180        = 3'd2,
    ORIENT_ROT270        = 3'd3,
    ORIENT_MIRROR_H      = 3'd4,
    ORIENT_MIRROR_V      = 3'd5,
    ORIENT_TRANSPOSE     = 3'd6,
    ORIENT_ANTITRANSPOSE = 3'd7
  } sym_e;

  typedef struct packed {
    logic signed [SCALE_W-1:0] scale;
    logic signed [OFFS_W-1:0]  offset;
    sym_e                      symmetry;
    logic [SIZE_W-1:0]         block_size;
    logic [COORD_W-1:0]        origin_x;
    logic [COORD_W-1:0]        origin_y;
  } cfg_t;

endpackage

// File: rtl/ibsm_cfg.sv
// Configuration register file and effective block edge length.
module ibsm_cfg #(
  parameter int MAX_BLOCK = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ibsm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ibsm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output ibsm_pkg::cfg_t                        cfg_o,
  output logic                                  size_wr_o,
  output logic [$clog2(MAX_BLOCK)-1:0]          edge_m1_o
);

  localparam int CW = $clog2(MAX_BLOCK);
  localparam int NW = $clog2(MAX_BLOCK + 1);

  ibsm_pkg::cfg_t cfg_q;
  logic [NW-1:0]  edge_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale      <= 16'sd4096;
      cfg_q.offset     <= '0;
      cfg_q.symmetry   <= ibsm_pkg::ORIENT_IDENT;
      cfg_q.block_size <= 6'd4;
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ibsm_pkg::REG_SCALE:    cfg_q.scale <= cfg_wdata_i;
        ibsm_pkg::REG_OFFSET:   cfg_q.offset <= cfg_wdata_i[ibsm_pkg::OFFS_W-1:0];
        ibsm_pkg::REG_SYMMETRY:
          cfg_q.symmetry <= ibsm_pkg::sym_e'(cfg_wdata_i[ibsm_pkg::SYM_W-1:0]);
        ibsm_pkg::REG_SIZE:     cfg_q.block_size <= cfg_wdata_i[ibsm_pkg::SIZE_W-1:0];
        ibsm_pkg::REG_ORIGIN_X: cfg_q.origin_x <= cfg_wdata_i[ibsm_pkg::COORD_W-1:0];
        ibsm_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= cfg_wdata_i[ibsm_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_q.block_size == '0) begin
      edge_len = NW'(1);
    end else if (32'(cfg_q.block_size) > 32'(MAX_BLOCK)) begin
      edge_len = NW'(MAX_BLOCK);
    end else begin
      edge_len = NW'(cfg_q.block_size);
    end
  end

  assign edge_m1_o = CW'(edge_len - NW'(1));
  assign size_wr_o = cfg_we_i && (cfg_idx_i == ibsm_pkg::REG_SIZE);
  assign cfg_o     = cfg_q;

endmodule

// File: rtl/ibsm_pixel.sv
// Contrast scaling, brightness offset and clamping of one pixel.
module ibsm_pixel (
  input  logic [ibsm_pkg::PIX_W-1:0]          pix_i,
  input  logic signed [ibsm_pkg::SCALE_W-1:0] scale_i,
  input  logic signed [ibsm_pkg::OFFS_W-1:0]  offset_i,
  output logic [ibsm_pkg::PIX_W-1:0]          pix_o
);

  localparam int PROD_W = ibsm_pkg::PIX_W + 1 + ibsm_pkg::SCALE_W;
  localparam int QUOT_W = PROD_W - ibsm_pkg::FRAC_BITS;
  localparam int SUM_W  = QUOT_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [QUOT_W-1:0] quot;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    prod = $signed({1'b0, pix_i}) * scale_i;
    // Rounding toward zero: bias negative products before the arithmetic shift.
    biased = prod + (prod[PROD_W-1] ? PROD_W'((1 << ibsm_pkg::FRAC_BITS) - 1) : '0);
    quot = QUOT_W'(biased >>> ibsm_pkg::FRAC_BITS);
    sum = SUM_W'(quot) + SUM_W'(offset_i);
    if (sum < 0) begin
      pix_o = '0;
    end else if (sum > SUM_W'(ibsm_pkg::PIX_MAX)) begin
      pix_o = ibsm_pkg::PIX_W'(ibsm_pkg::PIX_MAX);
    end else begin
      pix_o = sum[ibsm_pkg::PIX_W-1:0];
    end
  end

endmodule

// File: rtl/ibsm_coord.sv
// Symmetry map of a source position to wrapped destination coordinates.
module ibsm_coord #(
  parameter int MAX_BLOCK = 32,
  parameter int IMAGE_DIM = 4096
) (
  input  logic [$clog2(MAX_BLOCK)-1:0]    col_i,
  input  logic [$clog2(MAX_BLOCK)-1:0]    row_i,
  input  logic [$clog2(MAX_BLOCK)-1:0]    edge_m1_i,
  input  ibsm_pkg::sym_e                  symmetry_i,
  input  logic [ibsm_pkg::COORD_W-1:0]    origin_x_i,
  input  logic [ibsm_pkg::COORD_W-1:0]    origin_y_i,
  output logic [ibsm_pkg::COORD_W-1:0]    x_o,
  output logic [ibsm_pkg::COORD_W-1:0]    y_o
);

  localparam int CW = $clog2(MAX_BLOCK);
  localparam int SW = ibsm_pkg::SUM_W;
  localparam int QSTEPS = $clog2(((2 ** SW) - 1) / IMAGE_DIM + 1);

  logic          keep_axes;
  logic          pos_x;
  logic          pos_y;
  logic [CW-1:0] fx;
  logic [CW-1:0] fy;
  logic [CW-1:0] tx;
  logic [CW-1:0] ty;
  logic [SW-1:0] rem_x;
  logic [SW-1:0] rem_y;

  always_comb begin
    unique case (symmetry_i)
      ibsm_pkg::ORIENT_IDENT: begin
        keep_axes = 1'b1; pos_x = 1'b1; pos_y = 1'b1;
      end
      ibsm_pkg::ORIENT_ROT90: begin
        keep_axes = 1'b0; pos_x = 1'b1; pos_y = 1'b0;
      end
      ibsm_pkg::ORIENT_ROT180: begin
        keep_axes = 1'b1; pos_x = 1'b0; pos_y = 1'b0;
      end
      ibsm_pkg::ORIENT_ROT270: begin
        keep_axes = 1'b0; pos_x = 1'b0; pos_y = 1'b1;
      end
      ibsm_pkg::ORIENT_MIRROR_H: begin
        keep_axes = 1'b1; pos_x = 1'b0; pos_y = 1'b1;
      end
      ibsm_pkg::ORIENT_MIRROR_V: begin
        keep_axes = 1'b1; pos_x = 1'b1; pos_y = 1'b0;
      end
      ibsm_pkg::ORIENT_TRANSPOSE: begin
        keep_axes = 1'b0; pos_x = 1'b1; pos_y = 1'b1;
      end
      ibsm_pkg::ORIENT_ANTITRANSPOSE: begin
        keep_axes = 1'b0; pos_x = 1'b0; pos_y = 1'b0;
      end
      default: begin
        keep_axes = 1'b1; pos_x = 1'b1; pos_y = 1'b1;
      end
    endcase
  end

  always_comb begin
    fx = pos_x ? col_i : CW'(edge_m1_i - col_i);
    fy = pos_y ? row_i : CW'(edge_m1_i - row_i);
    tx = keep_axes ? fx : fy;
    ty = keep_axes ? fy : fx;
  end

  // The wrap reduces the sum by shifted multiples of the image size, one
  // quotient bit per step.
  always_comb begin
    rem_x = SW'(origin_x_i) + SW'(tx);
    rem_y = SW'(origin_y_i) + SW'(ty);
    for (int k = QSTEPS - 1; k >= 0; k--) begin
      if (32'(rem_x) >= (32'(IMAGE_DIM) << k)) begin
        rem_x = rem_x - SW'(32'(IMAGE_DIM) << k);
      end
      if (32'(rem_y) >= (32'(IMAGE_DIM) << k)) begin
        rem_y = rem_y - SW'(32'(IMAGE_DIM) << k);
      end
    end
    x_o = rem_x[ibsm_pkg::COORD_W-1:0];
    y_o = rem_y[ibsm_pkg::COORD_W-1:0];
  end

endmodule

// File: rtl/ifs_block_symmetry_map.sv
// Top level of the IFS block symmetry map: position counters and two-stage pipeline.
// The block takes one pixel word per cycle unless stalled and returns one result
// word per pixel: the pixel and its source position are registered
// on entry, and the contrast multiply, clamp and symmetry coordinate map then
// run combinationally into the output register. Under a stalled output the entry
// register still fills, so two words can be held inside. The source position
// counters advance on each accepted pixel and return to zero after the block's
// last pixel or when the block size register is written; configuration is
// expected to change only while no words are in flight.
module ifs_block_symmetry_map #(
  parameter int MAX_BLOCK = 32,
  parameter int IMAGE_DIM = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ibsm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ibsm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [7:0] src_pixel
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] out_pixel, [19:8] out_x, [31:20] out_y
  output logic [31:0]                           m_axis_tdata,
  output logic                                  m_axis_tlast   // block_done
);

  localparam int CW = $clog2(MAX_BLOCK);

  ibsm_pkg::cfg_t                    cfg;
  logic                              size_wr;
  logic [CW-1:0]                     edge_m1;

  logic [CW-1:0]                     col_q, col_d;
  logic [CW-1:0]                     row_q, row_d;
  logic [CW-1:0]                     col_cl;
  logic [CW-1:0]                     row_cl;
  logic                              in_done;
  logic                              in_acc;

  logic                              s1_valid_q;
  logic [ibsm_pkg::PIX_W-1:0]        s1_pix_q;
  logic [CW-1:0]                     s1_col_q;
  logic [CW-1:0]                     s1_row_q;
  logic                              s1_done_q;
  logic                              s1_adv;
  logic                              out_room;

  logic [ibsm_pkg::PIX_W-1:0]        pix_res;
  logic [ibsm_pkg::COORD_W-1:0]      x_res;
  logic [ibsm_pkg::COORD_W-1:0]      y_res;

  logic                              out_valid_q;
  logic [ibsm_pkg::PIX_W-1:0]        out_pix_q;
  logic [ibsm_pkg::COORD_W-1:0]      out_x_q;
  logic [ibsm_pkg::COORD_W-1:0]      out_y_q;
  logic                              out_done_q;

  ibsm_cfg #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .size_wr_o   (size_wr),
    .edge_m1_o   (edge_m1)
  );

  assign out_room      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_room;
  assign s_axis_tready = !s1_valid_q || out_room;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_cl  = (col_q > edge_m1) ? edge_m1 : col_q;
    row_cl  = (row_q > edge_m1) ? edge_m1 : row_q;
    in_done = (col_cl >= edge_m1) && (row_cl >= edge_m1);
    col_d   = col_q;
    row_d   = row_q;
    if (size_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (in_done) begin
        col_d = '0;
        row_d = '0;
      end else if (col_cl >= edge_m1) begin
        col_d = '0;
        row_d = CW'(row_cl + CW'(1));
      end else begin
        col_d = CW'(col_cl + CW'(1));
        row_d = row_cl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= s_axis_tdata;
      s1_col_q  <= col_cl;
      s1_row_q  <= row_cl;
      s1_done_q <= in_done;
    end
  end

  ibsm_pixel u_pixel (
    .pix_i    (s1_pix_q),
    .scale_i  (cfg.scale),
    .offset_i (cfg.offset),
    .pix_o    (pix_res)
  );

  ibsm_coord #(
    .MAX_BLOCK (MAX_BLOCK),
    .IMAGE_DIM (IMAGE_DIM)
  ) u_coord (
    .col_i      (s1_col_q),
    .row_i      (s1_row_q),
    .edge_m1_i  (edge_m1),
    .symmetry_i (cfg.symmetry),
    .origin_x_i (cfg.origin_x),
    .origin_y_i (cfg.origin_y),
    .x_o        (x_res),
    .y_o        (y_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_room) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pix_q  <= pix_res;
      out_x_q    <= x_res;
      out_y_q    <= y_res;
      out_done_q <= s1_done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q, out_pix_q};
  assign m_axis_tlast  = out_done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= edge_m1) && (row_q <= edge_m1))
    else $error("Position counter beyond the block edge.");

  a_done_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_done) |=> (col_q == '0) && (row_q == '0))
    else $error("Counters did not return to zero after the last pixel.");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_room) |=> s1_valid_q && $stable(s1_pix_q) && $stable(s1_done_q))
    else $error("Entry register lost a word while the output was stalled.");

  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && (out_done_q == $past(s1_done_q)))
    else $error("Output register did not take the advancing word.");

endmodule
